### hw/rtl/tnl_pkg.sv
// shared types and constants for the transform nlerp interpolator
// used by tnl_norm and transform_nlerp_interpolator, depends on nothing

package tnl_pkg;

   // command codes
   localparam logic [1:0] CMD_LERP  = 2'd0;
   localparam logic [1:0] CMD_ANGLE = 2'd1;
   localparam logic [1:0] CMD_QUAT  = 2'd2;
   localparam logic [1:0] CMD_PASS  = 2'd3;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // angle wrap, all in q16.16
   localparam logic signed [35:0] HALF_TURN     = 36'sd11796480;
   localparam logic signed [35:0] NEG_HALF_TURN = -36'sd11796480;
   localparam logic [35:0]        FULL_TURN     = 36'd23592960;
   // half turn plus 183 full turns, keeps the wrap operand positive
   localparam logic signed [35:0] WRAP_BASE_LO  = 36'sd4329308160;
   localparam logic signed [35:0] WRAP_BASE_HI  = 36'sd4329308159;
   localparam logic signed [33:0] WRAP_OFF_LO   = -34'sd11796480;
   localparam logic signed [33:0] WRAP_OFF_HI   = -34'sd11796479;
   // floor(2^26 / 360), quotient estimate low by at most one
   localparam logic [17:0]        RECIP_360     = 18'd186413;

   localparam int SQRT_STEPS  = 33;
   localparam int DIV_STEPS   = 17;
   localparam int TOP_STAGES  = 10;
   localparam int NORM_STAGES = SQRT_STEPS + DIV_STEPS + 3;
   localparam int LATENCY     = TOP_STAGES + NORM_STAGES + 1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [3:0]        qneg;
      logic [3:0][31:0]  res;
   } side_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [64:0]       len_sq;
      logic [3:0][31:0]  mag;
   } norm_in_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic              zero;
      logic [3:0][16:0]  quo;
   } norm_out_type;

endpackage

### hw/rtl/tnl_norm.sv
// quaternion normalizer: pipelined rounded square root and four dividers
// depends on tnl_pkg

module tnl_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  tnl_pkg::norm_in_type  norm_in,
   output tnl_pkg::norm_out_type norm_out
);

   localparam int SQ    = tnl_pkg::SQRT_STEPS;
   localparam int DV    = tnl_pkg::DIV_STEPS;
   localparam int LAST  = tnl_pkg::NORM_STAGES - 1;
   localparam int RND   = SQ + 1;

   typedef struct packed {
      tnl_pkg::side_type side;
      logic              zero;
      logic [3:0][31:0]  mag;
   } meta_type;

   logic [LAST:0]     vld_ff;
   meta_type          meta_ff [0:LAST];
   logic [66:0]       rem_ff  [0:SQ];
   logic [32:0]       root_ff [0:SQ];
   logic [32:0]       rnd_ff;
   logic [32:0]       den_ff  [0:DV];
   logic [3:0][48:0]  dvr_ff  [0:DV];
   logic [3:0][16:0]  quo_ff  [0:DV];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAST-1:0], norm_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0].side <= norm_in.side;
      meta_ff[0].zero <= (norm_in.len_sq == 65'd0);
      meta_ff[0].mag  <= norm_in.mag;
      for (int k = 1; k <= LAST; k++) begin
         meta_ff[k] <= meta_ff[k-1];
      end
      rem_ff[0]  <= {2'b0, norm_in.len_sq};
      root_ff[0] <= '0;
   end

   // square root, one result bit per stage
   for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
      localparam int J = SQ - k;
      logic [66:0] trial;
      always_comb begin
         trial = ({34'b0, root_ff[k-1]} << (J + 1)) + (67'd1 << (2 * J));
      end
      always_ff @(posedge clock) begin
         if (rem_ff[k-1] >= trial) begin
            rem_ff[k]  <= rem_ff[k-1] - trial;
            root_ff[k] <= root_ff[k-1] | (33'd1 << J);
         end else begin
            rem_ff[k]  <= rem_ff[k-1];
            root_ff[k] <= root_ff[k-1];
         end
      end
   end

   // round to nearest, then set up numerators with half the divisor added
   always_ff @(posedge clock) begin
      if (rem_ff[SQ] > {34'b0, root_ff[SQ]}) begin
         rnd_ff <= root_ff[SQ] + 33'd1;
      end else begin
         rnd_ff <= root_ff[SQ];
      end
      den_ff[0] <= rnd_ff;
      quo_ff[0] <= '0;
      for (int i = 0; i < 4; i++) begin
         dvr_ff[0][i] <= {1'b0, meta_ff[RND].mag[i], 16'b0} + {17'b0, rnd_ff[32:1]};
      end
   end

   // restoring division, one quotient bit per stage per lane
   for (genvar m = 1; m <= DV; m++) begin : g_div
      localparam int B = DV - m;
      logic [49:0] shifted;
      always_comb begin
         shifted = {17'b0, den_ff[m-1]} << B;
      end
      always_ff @(posedge clock) begin
         den_ff[m] <= den_ff[m-1];
         for (int i = 0; i < 4; i++) begin
            if ({1'b0, dvr_ff[m-1][i]} >= shifted) begin
               dvr_ff[m][i] <= dvr_ff[m-1][i] - shifted[48:0];
               quo_ff[m][i] <= quo_ff[m-1][i] | (17'd1 << B);
            end else begin
               dvr_ff[m][i] <= dvr_ff[m-1][i];
               quo_ff[m][i] <= quo_ff[m-1][i];
            end
         end
      end
   end

   always_comb begin
      norm_out.valid = vld_ff[LAST];
      norm_out.side  = meta_ff[LAST].side;
      norm_out.zero  = meta_ff[LAST].zero;
      norm_out.quo   = quo_ff[DV];
   end

endmodule

### hw/rtl/transform_nlerp_interpolator.sv
// top level of the transform nlerp interpolator: front pipeline and output stage
// depends on tnl_pkg and tnl_norm

// One transform part enters per clock: a beat is taken on every edge where
// start is high, and busy is held low because the datapath is a fixed pipeline
// with no stall point. Each result appears on the rsp_ ports, marked by
// rsp_strobe for one cycle; the receiver must take it then, since nothing
// holds it. Most of the pipeline depth is in the normalizer:
// a 33-stage rounded square root (one root bit per stage) followed by a
// 17-stage divider per quaternion lane, plus ten front stages for the dot
// product, the angle wrap and the blend multiply. All commands travel the full
// pipeline, so results always leave in the order their beats arrived.

module transform_nlerp_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_prev_0,
   input  logic signed [31:0] req_prev_1,
   input  logic signed [31:0] req_prev_2,
   input  logic signed [31:0] req_prev_3,
   input  logic signed [31:0] req_curr_0,
   input  logic signed [31:0] req_curr_1,
   input  logic signed [31:0] req_curr_2,
   input  logic signed [31:0] req_curr_3,
   input  logic [16:0]        req_weight,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_0,
   output logic signed [31:0] rsp_out_1,
   output logic signed [31:0] rsp_out_2,
   output logic signed [31:0] rsp_out_3
);

   localparam int NS = tnl_pkg::TOP_STAGES;

   logic accept;
   logic [3:0][31:0] prev_in, curr_in;

   // pipeline valid line and carried fields
   logic [NS:1]        vld_ff;
   logic [1:0]         cmd_ff  [1:NS];
   logic [3:0][31:0]   prev_ff [1:8];
   logic [3:0][31:0]   curr_ff [1:8];
   logic [16:0]        wgt_ff  [1:6];

   // dot product sign for the short arc
   logic signed [63:0] dot_ff   [4];
   logic signed [64:0] dpair_ff [2];
   logic               dneg_ff;
   logic signed [65:0] dsum;

   // angle wrap lanes
   logic [2:0][32:0]   dif_ff [2:5];
   logic [2:0]         gt_ff  [3:5];
   logic [2:0]         lt_ff  [3:5];
   logic [2:0][35:0]   wx_ff  [3:4];
   logic [2:0][9:0]    quo_ff;
   logic [2:0][25:0]   rem_ff;

   // blend lanes
   logic [3:0][32:0]   cc_ff;
   logic [3:0][33:0]   del_ff;
   logic [3:0][51:0]   prd_ff;
   logic [3:0][35:0]   qv_ff;
   logic [3:0][63:0]   sq_ff;
   logic [3:0][31:0]   mag_ff  [9:10];
   tnl_pkg::side_type  side_ff [9:10];
   logic [1:0][64:0]   spair_ff;

   // next values
   logic [2:0][32:0]   dif_in;
   logic [2:0]         gt_in, lt_in;
   logic [2:0][35:0]   wx_in;
   logic [2:0][9:0]    quo_in;
   logic [2:0][25:0]   rem_in;
   logic [3:0][32:0]   cc_in;
   logic [3:0][33:0]   del_in;
   logic [3:0][51:0]   prd_in;
   logic [3:0][35:0]   qv_in;
   logic [3:0][63:0]   sq_in;
   logic [3:0][31:0]   mag_in;
   tnl_pkg::side_type  side_in;
   logic [1:0][64:0]   spair_in;

   tnl_pkg::norm_in_type  norm_in;
   tnl_pkg::norm_out_type norm_out;

   logic               strobe_ff;
   logic [3:0][31:0]   out_ff, out_in;

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign prev_in = {req_prev_3, req_prev_2, req_prev_1, req_prev_0};
   assign curr_in = {req_curr_3, req_curr_2, req_curr_1, req_curr_0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[NS-1:1], accept};
         strobe_ff <= norm_out.valid;
      end
   end

   // stage 1: capture the beat, clamp the weight to one
   always_ff @(posedge clock) begin
      cmd_ff[1]  <= req_command;
      prev_ff[1] <= prev_in;
      curr_ff[1] <= curr_in;
      wgt_ff[1]  <= (req_weight > tnl_pkg::ONE_Q16) ? tnl_pkg::ONE_Q16 : req_weight;
      for (int k = 2; k <= NS; k++) begin
         cmd_ff[k] <= cmd_ff[k-1];
      end
      for (int k = 2; k <= 8; k++) begin
         prev_ff[k] <= prev_ff[k-1];
         curr_ff[k] <= curr_ff[k-1];
      end
      for (int k = 2; k <= 6; k++) begin
         wgt_ff[k] <= wgt_ff[k-1];
      end
   end

   always_comb begin
      logic signed [51:0] rnd;
      logic signed [35:0] qs, qa;
      logic [25:0]        remc;
      logic signed [33:0] wrp;
      logic signed [32:0] cs;
      logic [35:0]        yprod;

      // stage 2: differences and dot products
      for (int i = 0; i < 3; i++) begin
         dif_in[i] = $signed({curr_ff[1][i][31], curr_ff[1][i]})
                   - $signed({prev_ff[1][i][31], prev_ff[1][i]});
      end

      // stage 3: pick the wrap direction and bias the operand positive
      for (int i = 0; i < 3; i++) begin
         gt_in[i] = $signed(dif_ff[2][i]) > tnl_pkg::HALF_TURN;
         lt_in[i] = $signed(dif_ff[2][i]) < tnl_pkg::NEG_HALF_TURN;
         wx_in[i] = $signed({{3{dif_ff[2][i][32]}}, dif_ff[2][i]})
                  + (gt_in[i] ? tnl_pkg::WRAP_BASE_HI : tnl_pkg::WRAP_BASE_LO);
      end

      // stage 4: quotient estimate by reciprocal of 360 on the integer degrees
      for (int i = 0; i < 3; i++) begin
         yprod     = wx_ff[3][i][33:16] * tnl_pkg::RECIP_360;
         quo_in[i] = yprod[35:26];
      end
      dsum = dpair_ff[0] + dpair_ff[1];

      // stage 5: remainder, short arc flip of current
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = 26'(wx_ff[4][i] - {26'b0, quo_ff[i]} * tnl_pkg::FULL_TURN);
      end
      for (int i = 0; i < 4; i++) begin
         cs       = $signed({curr_ff[4][i][31], curr_ff[4][i]});
         cc_in[i] = dneg_ff ? -cs : cs;
      end

      // stage 6: final wrap correction and delta select
      for (int i = 0; i < 4; i++) begin
         del_in[i] = $signed({cc_ff[i][32], cc_ff[i]})
                   - $signed({{2{prev_ff[5][i][31]}}, prev_ff[5][i]});
      end
      for (int i = 0; i < 3; i++) begin
         remc = (rem_ff[i] >= tnl_pkg::FULL_TURN[25:0])
              ? rem_ff[i] - tnl_pkg::FULL_TURN[25:0] : rem_ff[i];
         wrp  = $signed({8'b0, remc})
              + (gt_ff[5][i] ? tnl_pkg::WRAP_OFF_HI : tnl_pkg::WRAP_OFF_LO);
         // quaternion lanes keep the short arc delta from above
         if (cmd_ff[5] == tnl_pkg::CMD_ANGLE && (gt_ff[5][i] || lt_ff[5][i])) begin
            del_in[i] = wrp;
         end else if (cmd_ff[5] != tnl_pkg::CMD_QUAT) begin
            del_in[i] = $signed({dif_ff[5][i][32], dif_ff[5][i]});
         end
      end

      // stage 7: blend multiply
      for (int i = 0; i < 4; i++) begin
         prd_in[i] = $signed(del_ff[i]) * $signed({1'b0, wgt_ff[6]});
      end

      // stage 8: round half up and add previous
      for (int i = 0; i < 4; i++) begin
         rnd      = ($signed(prd_ff[i]) + 52'sd32768) >>> 16;
         qv_in[i] = $signed(rnd[35:0])
                  + $signed({{4{prev_ff[7][i][31]}}, prev_ff[7][i]});
      end

      // stage 9: saturate, magnitudes and squares
      side_in.cmd = cmd_ff[8];
      for (int i = 0; i < 4; i++) begin
         qs                = $signed(qv_ff[i]);
         qa                = qs[35] ? -qs : qs;
         mag_in[i]         = qa[31:0];
         sq_in[i]          = mag_in[i] * mag_in[i];
         side_in.qneg[i]   = qs[35];
         if (qs[35:31] == 5'b00000 || qs[35:31] == 5'b11111) begin
            side_in.res[i] = qs[31:0];
         end else if (qs[35]) begin
            side_in.res[i] = 32'h8000_0000;
         end else begin
            side_in.res[i] = 32'h7fff_ffff;
         end
         if (cmd_ff[8] == tnl_pkg::CMD_PASS) begin
            side_in.res[i] = curr_ff[8][i];
         end else if (i == 3 && cmd_ff[8] != tnl_pkg::CMD_QUAT) begin
            side_in.res[i] = '0;
         end
      end

      // stage 10: first half of the squared length
      spair_in[0] = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      spair_in[1] = {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         dot_ff[i] <= $signed(prev_ff[1][i]) * $signed(curr_ff[1][i]);
      end
      dif_ff[2] <= dif_in;
      for (int k = 3; k <= 5; k++) begin
         dif_ff[k] <= dif_ff[k-1];
      end
      dpair_ff[0] <= dot_ff[0] + dot_ff[1];
      dpair_ff[1] <= dot_ff[2] + dot_ff[3];
      gt_ff[3]    <= gt_in;
      lt_ff[3]    <= lt_in;
      wx_ff[3]    <= wx_in;
      for (int k = 4; k <= 5; k++) begin
         gt_ff[k] <= gt_ff[k-1];
         lt_ff[k] <= lt_ff[k-1];
      end
      wx_ff[4]    <= wx_ff[3];
      quo_ff      <= quo_in;
      dneg_ff     <= dsum[65];
      rem_ff      <= rem_in;
      cc_ff       <= cc_in;
      del_ff      <= del_in;
      prd_ff      <= prd_in;
      qv_ff       <= qv_in;
      sq_ff       <= sq_in;
      mag_ff[9]   <= mag_in;
      mag_ff[10]  <= mag_ff[9];
      side_ff[9]  <= side_in;
      side_ff[10] <= side_ff[9];
      spair_ff    <= spair_in;
   end

   always_comb begin
      norm_in.valid  = vld_ff[NS];
      norm_in.side   = side_ff[10];
      norm_in.len_sq = spair_ff[0] + spair_ff[1];
      norm_in.mag    = mag_ff[10];
   end

   tnl_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_in  (norm_in),
      .norm_out (norm_out)
   );

   // output stage: apply signs to the normalized lanes or take the carried result
   always_comb begin
      logic [31:0] mv;
      for (int i = 0; i < 4; i++) begin
         mv = {15'b0, norm_out.quo[i]};
         if (norm_out.side.cmd != tnl_pkg::CMD_QUAT) begin
            out_in[i] = norm_out.side.res[i];
         end else if (norm_out.zero) begin
            out_in[i] = '0;
         end else begin
            out_in[i] = norm_out.side.qneg[i] ? -mv : mv;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_out_0  = out_ff[0];
   assign rsp_out_1  = out_ff[1];
   assign rsp_out_2  = out_ff[2];
   assign rsp_out_3  = out_ff[3];

   // a result only ever follows a start beat by the fixed latency
   a_strobe_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, tnl_pkg::LATENCY))
      else $error("result strobe without matching start beat");

   // pass returns the current value untouched
   a_pass_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_command, tnl_pkg::LATENCY) == tnl_pkg::CMD_PASS
      |-> rsp_out_0 == $past(req_curr_0, tnl_pkg::LATENCY)
       && rsp_out_3 == $past(req_curr_3, tnl_pkg::LATENCY))
      else $error("pass result differs from current value");

   // triples leave the fourth lane at zero
   a_triple_w_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ($past(req_command, tnl_pkg::LATENCY) == tnl_pkg::CMD_LERP
                  || $past(req_command, tnl_pkg::LATENCY) == tnl_pkg::CMD_ANGLE)
      |-> rsp_out_3 == 32'sd0)
      else $error("triple result has nonzero fourth lane");

   // normalized lanes never exceed one by more than rounding
   a_quat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_command, tnl_pkg::LATENCY) == tnl_pkg::CMD_QUAT
      |-> rsp_out_0 <= 32'sd65537 && rsp_out_0 >= -32'sd65537
       && rsp_out_3 <= 32'sd65537 && rsp_out_3 >= -32'sd65537)
      else $error("normalized lane out of range");

endmodule

### dv/transform_nlerp_interpolator_test.sv
// self-checking testbench for transform_nlerp_interpolator: directed and random beats,
// predicted results compared field by field in arrival order
// depends on tnl_pkg and the rtl of the interpolator

module transform_nlerp_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] prev [4];
      logic signed [31:0] curr [4];
      logic [16:0]        weight;
   } part_type;

   typedef struct {
      logic signed [31:0] v [4];
   } blend_type;

   // rounded blend p + floor((d*w + 2^15) / 2^16), all exact in wide signed math
   function automatic logic signed [95:0] blend_step(logic signed [95:0] p,
                                                     logic signed [95:0] d,
                                                     logic signed [95:0] w);
      logic signed [95:0] t;
      t = d * w + 96'sd32768;
      return p + (t >>> 16);
   endfunction

   function automatic logic signed [31:0] clip32(logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fffffff;
      if (v < -96'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [95:0] wrap_degrees(logic signed [95:0] d);
      logic signed [95:0] h, f, k;
      h = 96'sd11796480;
      f = 96'sd23592960;
      if (d > h) begin
         k = (d - h + f - 1) / f;
         d = d - k * f;
      end else if (d < -h) begin
         k = (-h - d + f - 1) / f;
         d = d + k * f;
      end
      return d;
   endfunction

   function automatic blend_type predict_part(part_type it);
      blend_type r;
      logic signed [95:0] w, dot, q [4], c;
      logic [95:0] mag [4], len, root, n;
      w = (it.weight > tnl_pkg::ONE_Q16) ? 96'sd65536 : $signed({79'd0, it.weight});
      for (int i = 0; i < 4; i++) r.v[i] = '0;
      case (it.cmd)
         tnl_pkg::CMD_LERP: for (int i = 0; i < 3; i++)
            r.v[i] = clip32(blend_step(it.prev[i], 96'(it.curr[i]) - it.prev[i], w));
         tnl_pkg::CMD_ANGLE: for (int i = 0; i < 3; i++)
            r.v[i] = clip32(blend_step(it.prev[i],
                            wrap_degrees(96'(it.curr[i]) - it.prev[i]), w));
         tnl_pkg::CMD_QUAT: begin
            dot = 0;
            for (int i = 0; i < 4; i++) dot += 96'(it.prev[i]) * 96'(it.curr[i]);
            len = 0;
            for (int i = 0; i < 4; i++) begin
               c = (dot < 0) ? -96'(it.curr[i]) : 96'(it.curr[i]);
               q[i] = blend_step(it.prev[i], c - it.prev[i], w);
               mag[i] = (q[i] < 0) ? -q[i] : q[i];
               len += mag[i] * mag[i];
            end
            if (len == 0) begin
               for (int i = 0; i < 4; i++) r.v[i] = clip32(q[i]);
            end else begin
               // floor root by bisection, then round to nearest
               root = 0;
               for (int b = 47; b >= 0; b--)
                  if ((root | (96'd1 << b)) * (root | (96'd1 << b)) <= len)
                     root = root | (96'd1 << b);
               if (len - root * root > root) root = root + 1;
               for (int i = 0; i < 4; i++) begin
                  n = ((mag[i] << 16) + (root >> 1)) / root;
                  r.v[i] = clip32((q[i] < 0) ? -$signed(n) : $signed(n));
               end
            end
         end
         default: for (int i = 0; i < 4; i++) r.v[i] = it.curr[i];
      endcase
      return r;
   endfunction

   class part_scoreboard;
      blend_type pending [$];
      int        errors = 0;
      int        checked = 0;

      function void note_part(part_type it);
         pending.push_back(predict_part(it));
      endfunction

      function void check_result(logic signed [31:0] got [4]);
         blend_type e;
         if (pending.size() == 0) begin
            $error("result with no part outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         for (int i = 0; i < 4; i++)
            if (got[i] !== e.v[i]) begin
               $error("out_%0d expected %h got %h", i, e.v[i], got[i]);
               errors++;
            end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_command = tnl_pkg::CMD_LERP;
   logic signed [31:0] req_prev_0 = 0, req_prev_1 = 0, req_prev_2 = 0, req_prev_3 = 0;
   logic signed [31:0] req_curr_0 = 0, req_curr_1 = 0, req_curr_2 = 0, req_curr_3 = 0;
   logic [16:0]        req_weight = 0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3;

   part_scoreboard sb = new();
   int sender_idle = 0;   // percent of cycles the sender holds off
   int cycles = 0;
   int cmd_seen [4] = '{0, 0, 0, 0};

   transform_nlerp_interpolator dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // results cannot be held off, so every strobe is checked on the edge that ends it
   always @(posedge clock) begin
      logic signed [31:0] got [4];
      got = '{rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3};
      if (!reset && rsp_strobe) sb.check_result(got);
   end

   // watchdog, far beyond the slowest correct run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("transform_nlerp_interpolator_test NOT OK");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_comp(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 131072)) - 65536;       // near unit range
         2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
         3: return $signed($urandom_range(0, 47185920)) - 23592960;  // +-360 degrees
         default: return 0;
      endcase
   endfunction

   function automatic part_type random_part();
      part_type it;
      int kind;
      it.cmd = 2'($urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      kind = (kind < 4) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 2 : (kind < 9) ? 3 : 4;
      for (int i = 0; i < 4; i++) begin
         it.prev[i] = ($urandom_range(0, 15) == 0) ? rand_comp($urandom_range(0, 4))
                                                   : rand_comp(kind);
         it.curr[i] = ($urandom_range(0, 15) == 0) ? rand_comp($urandom_range(0, 4))
                                                   : rand_comp(kind);
      end
      case ($urandom_range(0, 7))
         0: it.weight = '0;
         1: it.weight = tnl_pkg::ONE_Q16;
         2: it.weight = 17'($urandom_range(65537, 131071));
         default: it.weight = 17'($urandom_range(0, 65536));
      endcase
      return it;
   endfunction

   // drives one beat; start stays high across back-to-back beats
   task automatic send_part(part_type it);
      while (sender_idle > 0 && $urandom_range(1, 100) <= sender_idle) begin
         start <= 0;
         @(posedge clock);
      end
      start       <= 1;
      req_command <= it.cmd;
      {req_prev_0, req_prev_1, req_prev_2, req_prev_3} <=
         {it.prev[0], it.prev[1], it.prev[2], it.prev[3]};
      {req_curr_0, req_curr_1, req_curr_2, req_curr_3} <=
         {it.curr[0], it.curr[1], it.curr[2], it.curr[3]};
      req_weight  <= it.weight;
      do @(posedge clock); while (busy);
      sb.note_part(it);
      cmd_seen[it.cmd]++;
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_quad(logic [1:0] cmd, logic signed [31:0] p [4],
                            logic signed [31:0] c [4], logic [16:0] w);
      part_type it;
      it.cmd = cmd; it.prev = p; it.curr = c; it.weight = w;
      send_part(it);
   endtask

   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] DEG = 32'sd65536;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command, clamp, angle wrap, zero length, 2^64 length
      send_quad(tnl_pkg::CMD_LERP, '{MINV, MAXV, 0, 0}, '{MAXV, MINV, 0, 0},
                tnl_pkg::ONE_Q16);
      send_quad(tnl_pkg::CMD_LERP, '{MAXV, MINV, 5, 0}, '{MINV, MAXV, -5, 0}, 17'h1ffff);
      send_quad(tnl_pkg::CMD_LERP, '{MAXV, MINV, 100, 0}, '{MAXV, MINV, 101, 0}, 32768);
      send_quad(tnl_pkg::CMD_LERP, '{1, 2, 3, 4}, '{5, 6, 7, 8}, 0);
      send_quad(tnl_pkg::CMD_ANGLE, '{170 * DEG, -170 * DEG, 0, 0}, '{-170 * DEG, 170 * DEG,
                180 * DEG, 0}, 32768);
      send_quad(tnl_pkg::CMD_ANGLE, '{0, 0, 0, 0}, '{-180 * DEG, 181 * DEG, -181 * DEG, 0},
                65536);
      send_quad(tnl_pkg::CMD_ANGLE, '{MINV, MAXV, MINV, 0}, '{MAXV, MINV, MINV, 0}, 40000);
      send_quad(tnl_pkg::CMD_ANGLE, '{MAXV, MAXV, 0, 0}, '{MINV, 0, 720 * DEG, 0},
                17'h10001);
      send_quad(tnl_pkg::CMD_QUAT, '{0, 0, 0, 65536}, '{0, 0, 0, 65536}, 20000);
      send_quad(tnl_pkg::CMD_QUAT, '{0, 0, 0, 65536}, '{0, 0, 0, -65536}, 30000);
      send_quad(tnl_pkg::CMD_QUAT, '{65536, 0, 0, 0}, '{-65536, 0, 0, 0}, 32768);
      send_quad(tnl_pkg::CMD_QUAT, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 12345);
      send_quad(tnl_pkg::CMD_QUAT, '{MINV, MINV, MINV, MINV}, '{MINV, MINV, MINV, MINV},
                tnl_pkg::ONE_Q16);
      send_quad(tnl_pkg::CMD_QUAT, '{MINV, MAXV, MINV, MAXV}, '{MAXV, MINV, MAXV, MINV}, 0);
      send_quad(tnl_pkg::CMD_QUAT, '{MAXV, MAXV, MAXV, MAXV}, '{1, 1, 1, 1}, 17'h1ffff);
      send_quad(tnl_pkg::CMD_QUAT, '{1, 0, 0, 0}, '{0, 0, 0, 0}, 0);
      send_quad(tnl_pkg::CMD_PASS, '{1, 2, 3, 4}, '{MINV, MAXV, -1, 0}, 32768);
      send_quad(tnl_pkg::CMD_PASS, '{0, 0, 0, 0}, '{MAXV, MINV, 0, -1}, 17'h1ffff);

      // hold off until the pipeline has emptied
      drain();

      // random phases: back to back, sparse sender, light sender gaps, back to back
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle = (ph == 1) ? 55 : (ph == 2) ? 15 : 0;
         repeat (260) send_part(random_part());
      end

      drain();
      repeat (tnl_pkg::LATENCY + 10) @(posedge clock);
      $display("checked %0d results: lerp %0d, angle %0d, quat %0d, pass %0d", sb.checked,
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("phases covered back-to-back beats and sparse and light sender gaps");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("transform_nlerp_interpolator_test OK");
      else
         $display("transform_nlerp_interpolator_test NOT OK");
      $finish;
   end
endmodule
